>>> hdl/stp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse generator package
// Field widths, request codes, register indexes and the structures that
// travel between the rate divider, the step engine and the top level.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned RATE_W  = 20;
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned CIDX_W  = 2;

  localparam int unsigned TIME_BITS_DEF      = 32;
  localparam int unsigned CATCHUP_FACTOR_DEF = 4;

  // One second in microseconds; fits in a rate-wide word.
  localparam logic [RATE_W-1:0] ONE_SECOND_US = RATE_W'(1000000);

  localparam logic [PULSE_W-1:0] PULSE_LEN_RST = PULSE_W'(10);

  localparam logic [CIDX_W-1:0] CFG_STEP_RATE    = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] CFG_PULSE_LENGTH = CIDX_W'(1);
  localparam logic [CIDX_W-1:0] CFG_INVERT_DIR   = CIDX_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE     = 3'd0,
    OP_SET_TARGET = 3'd1,
    OP_ADD_TARGET = 3'd2,
    OP_RESET_POS  = 3'd3,
    OP_RESET_TIME = 3'd4
  } op_e;

  // New step rate and the spacing and remainder derived from it.
  typedef struct packed {
    logic              valid;
    logic [RATE_W-1:0] rate;
    logic [RATE_W-1:0] spacing;
    logic [RATE_W-1:0] remainder;
  } rate_upd_t;

  typedef struct packed {
    logic                     step_level;
    logic                     dir_level;
    logic                     dir_level_inverted;
    logic [WORD_W-1:0]        wait_hint;
    logic signed [WORD_W-1:0] position;
    logic                     on_target;
  } res_t;

endpackage

>>> hdl/stepper_step_pulse_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper step pulse generator
// Step and direction generator for one axis, driven by timestamped requests.
// ----------------------------------------------------------------------------
// Each request on the slave stream is an update at a microsecond timestamp
// or a command (set target, add to target, reset position, reset time),
// with the opcode in tuser. Every request yields exactly one result on the
// master stream: step and direction levels, a wait hint, the position and
// an on-target flag.
// A request is held in the input register until it can be evaluated, and is
// then written to the result register, which presents the result. One
// request per cycle is sustained while results are taken and no rate
// division runs; a stalled receiver holds the result register, and the
// input register fills and then drops tready.
// Writing the step rate over the configuration channel starts a divider
// that forms one quotient bit per cycle; both the configuration channel
// and the slave stream are held off meanwhile. Pulse length and
// direction inversion take effect at once.
// Reset clears the axis state and sets pulse length to 10 us, step rate and
// inversion to zero.
// ----------------------------------------------------------------------------
module stepper_step_pulse_generator #(
  parameter int unsigned TIME_BITS      = stp_pkg::TIME_BITS_DEF,
  parameter int unsigned CATCHUP_FACTOR = stp_pkg::CATCHUP_FACTOR_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // now_us, value
  input  logic [stp_pkg::OP_W-1:0]      s_axis_tuser,  // op
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // step_level, dir_level, dir_level_inverted, wait_hint, position,
  // on_target, zero fill
  output logic [71:0]                   m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [stp_pkg::CIDX_W-1:0]    cfg_index_i,
  input  logic [stp_pkg::RATE_W-1:0]    cfg_data_i
);
  import stp_pkg::*;

  logic                in_valid_q;
  logic [OP_W-1:0]     in_op_q;
  logic [WORD_W-1:0]   in_now_q;
  logic [WORD_W-1:0]   in_value_q;
  logic                out_valid_q;
  res_t                out_res_q;
  logic [PULSE_W-1:0]  pulse_len_q;
  logic                invert_q;

  logic                advance;
  logic                cfg_acc;
  logic                rate_start;
  logic [RATE_W-1:0]   rate_sat;
  logic                div_busy;
  rate_upd_t           div_upd;
  res_t                eng_res;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready) && !div_busy;
  assign s_axis_tready = (!in_valid_q || advance) && !div_busy;
  assign cfg_ready_o   = !div_busy;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign rate_start    = cfg_acc && (cfg_index_i == CFG_STEP_RATE);
  assign rate_sat      = (cfg_data_i > ONE_SECOND_US) ? ONE_SECOND_US : cfg_data_i;

  stp_rate_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rate_start),
    .rate_i  (rate_sat),
    .busy_o  (div_busy),
    .upd_o   (div_upd)
  );

  stp_engine #(
    .TIME_BITS      (TIME_BITS),
    .CATCHUP_FACTOR (CATCHUP_FACTOR)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_en_i   (advance),
    .op_i        (in_op_q),
    .now_i       (in_now_q),
    .value_i     (in_value_q),
    .pulse_len_i (pulse_len_q),
    .invert_i    (invert_q),
    .rate_upd_i  (div_upd),
    .res_o       (eng_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pulse_len_q <= PULSE_LEN_RST;
      invert_q    <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_acc && cfg_index_i == CFG_PULSE_LENGTH) begin
        pulse_len_q <= cfg_data_i[PULSE_W-1:0];
      end
      if (cfg_acc && cfg_index_i == CFG_INVERT_DIR) begin
        invert_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q    <= s_axis_tuser;
      in_now_q   <= s_axis_tdata[31:0];
      in_value_q <= s_axis_tdata[63:32];
    end
    if (advance) begin
      out_res_q <= eng_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_res_q.on_target, out_res_q.position,
                          out_res_q.wait_hint, out_res_q.dir_level_inverted,
                          out_res_q.dir_level, out_res_q.step_level};

  // Every evaluated request lands in the result register.
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("evaluated request did not produce a result");

  // The divider delivers the new spacing in the cycle after it forms its last bit.
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rate_start |-> ##(RATE_W + 1) div_upd.valid)
    else $error("rate divider latency is wrong");

  // A rate update never meets a request in the engine.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_upd.valid |-> !advance)
    else $error("request evaluated during a rate update");

endmodule

>>> hdl/stp_rate_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step rate divider
// Restoring divider that forms one second divided by the step rate, one
// quotient bit per cycle, and presents spacing and remainder for one cycle.
// ----------------------------------------------------------------------------
module stp_rate_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [stp_pkg::RATE_W-1:0]    rate_i,
  output logic                          busy_o,
  output stp_pkg::rate_upd_t            upd_o
);
  import stp_pkg::*;

  localparam int unsigned CNT_W = $clog2(RATE_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RATE_W - 1);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RATE_W-1:0] rate_q, rate_d;
  logic [RATE_W-1:0] rem_q, rem_d;
  logic [RATE_W-1:0] quo_q, quo_d;

  logic [RATE_W:0] shifted;
  logic [RATE_W:0] trial;
  logic            take;

  always_comb begin
    shifted = {rem_q, quo_q[RATE_W-1]};
    trial   = shifted - {1'b0, rate_q};
    take    = shifted >= {1'b0, rate_q};

    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rate_d = rate_q;
    rem_d  = rem_q;
    quo_d  = quo_q;

    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      rate_d = rate_i;
      rem_d  = '0;
      quo_d  = ONE_SECOND_US;
    end else if (run_q) begin
      rem_d = take ? trial[RATE_W-1:0] : shifted[RATE_W-1:0];
      quo_d = {quo_q[RATE_W-2:0], take};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == LAST_STEP) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rate_q <= rate_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  // A zero rate stops stepping, so spacing and remainder read as zero.
  always_comb begin
    upd_o.valid     = done_q;
    upd_o.rate      = rate_q;
    upd_o.spacing   = (rate_q == '0) ? '0 : quo_q;
    upd_o.remainder = (rate_q == '0) ? '0 : rem_q;
  end

  assign busy_o = run_q | done_q;

endmodule

>>> hdl/stp_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step engine
// Holds the axis state and works out, for one request, the new state and
// the result fields; also takes in a new step rate from the divider.
// ----------------------------------------------------------------------------
module stp_engine #(
  parameter int unsigned TIME_BITS      = stp_pkg::TIME_BITS_DEF,
  parameter int unsigned CATCHUP_FACTOR = stp_pkg::CATCHUP_FACTOR_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_en_i,
  input  logic [stp_pkg::OP_W-1:0]      op_i,
  input  logic [stp_pkg::WORD_W-1:0]    now_i,
  input  logic [stp_pkg::WORD_W-1:0]    value_i,
  input  logic [stp_pkg::PULSE_W-1:0]   pulse_len_i,
  input  logic                          invert_i,
  input  stp_pkg::rate_upd_t            rate_upd_i,
  output stp_pkg::res_t                 res_o
);
  import stp_pkg::*;

  localparam int unsigned CF_W   = $clog2(CATCHUP_FACTOR + 1);
  localparam int unsigned PROD_W = CF_W + RATE_W;

  typedef logic [TIME_BITS-1:0] time_t;

  // A time is reached once the wrapped difference lies in the lower half.
  function automatic logic reached(time_t now, time_t t);
    time_t d;
    d = now - t;
    return ~d[TIME_BITS-1];
  endfunction

  function automatic logic [WORD_W-1:0] clip_wait(time_t d);
    logic [63:0] w;
    w = 64'(d);
    return (w > 64'(32'hFFFF_FFFF)) ? '1 : w[WORD_W-1:0];
  endfunction

  function automatic time_t to_time(logic [63:0] w);
    return w[TIME_BITS-1:0];
  endfunction

  logic [WORD_W-1:0]   position_q, position_d;
  logic [WORD_W-1:0]   target_q, target_d;
  logic                moving_down_q, moving_down_d;
  logic                pulse_high_q, pulse_high_d;
  time_t               next_step_q, next_step_d;
  time_t               pulse_end_q, pulse_end_d;
  logic [RATE_W-1:0]   spacing_q, spacing_d;
  logic [RATE_W-1:0]   spacing_rem_q, spacing_rem_d;
  logic [RATE_W:0]     rem_sum_q, rem_sum_d;
  time_t               catchup_q, catchup_d;
  logic [WORD_W-1:0]   last_wait_q, last_wait_d;
  logic [RATE_W-1:0]   step_rate_q, step_rate_d;

  logic [PROD_W-1:0]   prod;
  time_t               now_t;
  time_t               sp_t;
  time_t               lag;
  time_t               base;
  logic [RATE_W:0]     rs_sum;
  logic                carry;
  logic                stop;
  logic [WORD_W-1:0]   new_target;
  logic [WORD_W-1:0]   upd_hint;
  logic [WORD_W-1:0]   hint;

  assign prod = PROD_W'(CATCHUP_FACTOR) * PROD_W'(rate_upd_i.spacing);

  always_comb begin
    position_d    = position_q;
    target_d      = target_q;
    moving_down_d = moving_down_q;
    pulse_high_d  = pulse_high_q;
    next_step_d   = next_step_q;
    pulse_end_d   = pulse_end_q;
    spacing_d     = spacing_q;
    spacing_rem_d = spacing_rem_q;
    rem_sum_d     = rem_sum_q;
    catchup_d     = catchup_q;
    last_wait_d   = last_wait_q;
    step_rate_d   = step_rate_q;

    now_t      = to_time(64'(now_i));
    sp_t       = to_time(64'(spacing_q));
    lag        = now_t - next_step_q;
    base       = (lag > catchup_q) ? now_t : next_step_q;
    rs_sum     = rem_sum_q + (RATE_W + 1)'(spacing_rem_q);
    carry      = rs_sum >= (RATE_W + 1)'(step_rate_q);
    stop       = 1'b0;
    new_target = target_q;
    upd_hint   = '0;
    hint       = last_wait_q;

    if (rate_upd_i.valid) begin
      step_rate_d   = rate_upd_i.rate;
      spacing_d     = rate_upd_i.spacing;
      spacing_rem_d = rate_upd_i.remainder;
      // Keep the previous step instant and re-space from it.
      if (rate_upd_i.rate != '0) begin
        next_step_d = next_step_q - sp_t + to_time(64'(rate_upd_i.spacing));
      end
      catchup_d = to_time(64'(prod));
    end else if (item_en_i) begin
      unique case (op_e'(op_i))
        OP_UPDATE: begin
          if (pulse_high_q) begin
            if (reached(now_t, pulse_end_q)) begin
              pulse_high_d = 1'b0;
              if (reached(now_t, next_step_q)) begin
                stop = 1'b1;
              end
            end else begin
              upd_hint = clip_wait(pulse_end_q - now_t);
              stop     = 1'b1;
            end
          end
          if (!stop) begin
            if (spacing_q == '0 || position_q == target_q) begin
              upd_hint = WORD_W'(ONE_SECOND_US);
            end else if (reached(now_t, next_step_q)) begin
              pulse_high_d = 1'b1;
              pulse_end_d  = now_t + to_time(64'(pulse_len_i));
              rem_sum_d    = carry ? rs_sum - (RATE_W + 1)'(step_rate_q) : rs_sum;
              next_step_d  = base + sp_t + to_time(64'(carry));
              position_d   = position_q + (moving_down_q ? '1 : WORD_W'(1));
            end else begin
              upd_hint = clip_wait(next_step_q - now_t);
            end
          end
          last_wait_d = upd_hint;
          hint        = upd_hint;
        end
        OP_SET_TARGET, OP_ADD_TARGET: begin
          new_target    = (op_e'(op_i) == OP_SET_TARGET) ? value_i : target_q + value_i;
          target_d      = new_target;
          moving_down_d = $signed(new_target) < $signed(position_q);
        end
        OP_RESET_POS: begin
          position_d    = '0;
          target_d      = '0;
          moving_down_d = 1'b0;
          rem_sum_d     = '0;
          pulse_high_d  = 1'b0;
        end
        OP_RESET_TIME: begin
          next_step_d = now_t;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_o.step_level         = pulse_high_d;
    res_o.dir_level          = moving_down_d ^ invert_i;
    res_o.dir_level_inverted = ~(moving_down_d ^ invert_i);
    res_o.wait_hint          = hint;
    res_o.position           = position_d;
    res_o.on_target          = position_d == target_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q    <= '0;
      target_q      <= '0;
      moving_down_q <= 1'b0;
      pulse_high_q  <= 1'b0;
      next_step_q   <= '0;
      pulse_end_q   <= '0;
      spacing_q     <= '0;
      spacing_rem_q <= '0;
      rem_sum_q     <= '0;
      catchup_q     <= '0;
      last_wait_q   <= '0;
      step_rate_q   <= '0;
    end else begin
      position_q    <= position_d;
      target_q      <= target_d;
      moving_down_q <= moving_down_d;
      pulse_high_q  <= pulse_high_d;
      next_step_q   <= next_step_d;
      pulse_end_q   <= pulse_end_d;
      spacing_q     <= spacing_d;
      spacing_rem_q <= spacing_rem_d;
      rem_sum_q     <= rem_sum_d;
      catchup_q     <= catchup_d;
      last_wait_q   <= last_wait_d;
      step_rate_q   <= step_rate_d;
    end
  end

endmodule
